[hdl/psd_pkg.sv]
// shared types, constants and helpers for the path segment crossing detector
package psd_pkg;

  localparam int unsigned CoordWidth = 32;
  localparam int unsigned DiffWidth  = CoordWidth + 1;
  localparam int unsigned ProdWidth  = 2 * DiffWidth;
  localparam int unsigned SumWidth   = ProdWidth + 1;
  localparam int unsigned CfgAddrWidth = 2;

  typedef logic signed [CoordWidth-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   first_point;
    logic   last_point;
  } in_beat_t;

  typedef struct packed {
    logic segment_hit;
    logic path_crosses;
    logic path_done;
  } out_beat_t;

  typedef enum logic [CfgAddrWidth-1:0] {
    CFG_BARRIER_START_X = 2'd0,
    CFG_BARRIER_START_Y = 2'd1,
    CFG_BARRIER_END_X   = 2'd2,
    CFG_BARRIER_END_Y   = 2'd3
  } cfg_addr_e;

  typedef enum logic [1:0] {
    ORIENT_COLLINEAR = 2'd0,
    ORIENT_CW        = 2'd1,
    ORIENT_CCW       = 2'd2
  } orient_e;

  // b lies inside the closed bounding box of a and c
  function automatic logic point_within(point_t a, point_t b, point_t c);
    logic x_ok;
    logic y_ok;
    x_ok = ((b.x <= a.x) || (b.x <= c.x)) && ((b.x >= a.x) || (b.x >= c.x));
    y_ok = ((b.y <= a.y) || (b.y <= c.y)) && ((b.y >= a.y) || (b.y >= c.y));
    return x_ok && y_ok;
  endfunction

endpackage

[hdl/psd_orient.sv]
// orientation of three points: registered cross products, then exact sign
module psd_orient
  import psd_pkg::*;
(
  input  logic    clk_i,
  input  logic    en_i,
  input  point_t  a_i,
  input  point_t  b_i,
  input  point_t  c_i,
  output orient_e orient_o
);

  logic signed [DiffWidth-1:0] dy_ab;
  logic signed [DiffWidth-1:0] dx_bc;
  logic signed [DiffWidth-1:0] dx_ab;
  logic signed [DiffWidth-1:0] dy_bc;
  logic signed [ProdWidth-1:0] prod_l_d, prod_l_q;
  logic signed [ProdWidth-1:0] prod_r_d, prod_r_q;
  logic signed [SumWidth-1:0]  cross_sum;

  assign dy_ab = DiffWidth'(b_i.y) - DiffWidth'(a_i.y);
  assign dx_bc = DiffWidth'(c_i.x) - DiffWidth'(b_i.x);
  assign dx_ab = DiffWidth'(b_i.x) - DiffWidth'(a_i.x);
  assign dy_bc = DiffWidth'(c_i.y) - DiffWidth'(b_i.y);

  assign prod_l_d = dy_ab * dx_bc;
  assign prod_r_d = dx_ab * dy_bc;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_l_q <= prod_l_d;
      prod_r_q <= prod_r_d;
    end
  end

  // full width difference, no overflow possible
  assign cross_sum = SumWidth'(prod_l_q) - SumWidth'(prod_r_q);

  always_comb begin
    if (cross_sum == '0) begin
      orient_o = ORIENT_COLLINEAR;
    end else if (!cross_sum[SumWidth-1]) begin
      orient_o = ORIENT_CW;
    end else begin
      orient_o = ORIENT_CCW;
    end
  end

endmodule

[hdl/path_segment_crossing_detector.sv]
// top level of the path segment crossing detector
// Path points stream in one beat per cycle as signed Q16.16 (x, y). Each beat
// tests the segment from the previous point of the path to this point against
// the barrier segment in the four configuration registers and returns one
// result beat: the hit of this segment, the running OR over the path, and the
// done flag copied from last_point. A beat with first_point, or with no held
// previous point, starts a new path and reports no hit; after a last_point
// beat the next beat always starts a new path. A new point is accepted every
// cycle while in_stall_o is low; the point lands in the input register when
// accepted and its result beat is presented after the product register of
// the four orientation units and the result register. The three stages form
// an elastic pipeline, so bubbles are filled while a result is held by
// out_stall_i. Barrier writes are taken at any time (cfg_ready_o is always
// high) but must only be made while no point is in flight.
module path_segment_crossing_detector
  import psd_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // point stream
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  in_beat_t                in_beat_i,
  // result stream
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output out_beat_t               out_beat_o,
  // barrier configuration
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CfgAddrWidth-1:0] cfg_addr_i,
  input  coord_t                  cfg_data_i
);

  // barrier registers
  point_t bar_start_q;
  point_t bar_end_q;

  // path state, updated as points are accepted
  point_t prev_q, prev_d;
  logic   have_prev_q, have_prev_d;

  // stage a: input register
  logic   a_valid_q;
  point_t a_p1_q;
  point_t a_p2_q;
  logic   a_live_q;
  logic   a_last_q;

  // stage b: products and bounding box checks
  logic       b_valid_q;
  logic       b_live_q;
  logic       b_last_q;
  logic [3:0] b_within_q, b_within_d;

  // stage c: result register and running or
  logic      out_valid_q;
  out_beat_t out_beat_q, out_beat_d;
  logic      hit_so_far_q, hit_so_far_d;

  // handshake
  logic ready_a, ready_b, ready_c;
  logic in_fire, load_b, load_c;

  orient_e o1, o2, o3, o4;
  logic    hit;
  logic    run_base;
  point_t  in_point;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bar_start_q <= '0;
      bar_end_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_addr_i)
        CFG_BARRIER_START_X: bar_start_q.x <= cfg_data_i;
        CFG_BARRIER_START_Y: bar_start_q.y <= cfg_data_i;
        CFG_BARRIER_END_X:   bar_end_q.x   <= cfg_data_i;
        CFG_BARRIER_END_Y:   bar_end_q.y   <= cfg_data_i;
        default:             bar_end_q     <= bar_end_q;
      endcase
    end
  end

  // elastic pipeline: a stage takes a beat when empty or when it drains
  assign ready_c = !out_valid_q || !out_stall_i;
  assign ready_b = !b_valid_q || ready_c;
  assign ready_a = !a_valid_q || ready_b;
  assign in_fire = in_valid_i && ready_a;
  assign load_b  = a_valid_q && ready_b;
  assign load_c  = b_valid_q && ready_c;

  assign in_stall_o = !ready_a;

  assign in_point.x = in_beat_i.point_x;
  assign in_point.y = in_beat_i.point_y;

  // previous point: cleared at the end of a path
  always_comb begin
    prev_d      = prev_q;
    have_prev_d = have_prev_q;
    if (in_fire) begin
      if (in_beat_i.last_point) begin
        prev_d      = '0;
        have_prev_d = 1'b0;
      end else begin
        prev_d      = in_point;
        have_prev_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      prev_q      <= prev_d;
      have_prev_q <= have_prev_d;
    end
  end

  // stage a
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (ready_a) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_p1_q   <= prev_q;
      a_p2_q   <= in_point;
      // segment exists only with a held previous point of the same path
      a_live_q <= have_prev_q && !in_beat_i.first_point;
      a_last_q <= in_beat_i.last_point;
    end
  end

  // stage b: orientation units hold their products in this stage
  psd_orient u_orient_1 (
    .clk_i    (clk_i),
    .en_i     (load_b),
    .a_i      (a_p1_q),
    .b_i      (a_p2_q),
    .c_i      (bar_start_q),
    .orient_o (o1)
  );

  psd_orient u_orient_2 (
    .clk_i    (clk_i),
    .en_i     (load_b),
    .a_i      (a_p1_q),
    .b_i      (a_p2_q),
    .c_i      (bar_end_q),
    .orient_o (o2)
  );

  psd_orient u_orient_3 (
    .clk_i    (clk_i),
    .en_i     (load_b),
    .a_i      (bar_start_q),
    .b_i      (bar_end_q),
    .c_i      (a_p1_q),
    .orient_o (o3)
  );

  psd_orient u_orient_4 (
    .clk_i    (clk_i),
    .en_i     (load_b),
    .a_i      (bar_start_q),
    .b_i      (bar_end_q),
    .c_i      (a_p2_q),
    .orient_o (o4)
  );

  // collinear touch checks, one per orientation
  assign b_within_d[0] = point_within(a_p1_q, bar_start_q, a_p2_q);
  assign b_within_d[1] = point_within(a_p1_q, bar_end_q, a_p2_q);
  assign b_within_d[2] = point_within(bar_start_q, a_p1_q, bar_end_q);
  assign b_within_d[3] = point_within(bar_start_q, a_p2_q, bar_end_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (ready_b) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_b) begin
      b_live_q   <= a_live_q;
      b_last_q   <= a_last_q;
      b_within_q <= b_within_d;
    end
  end

  // stage c: combine orientations into the hit and fold into the running or
  always_comb begin
    hit = 1'b0;
    if ((o1 != o2) && (o3 != o4)) begin
      hit = 1'b1;
    end
    if ((o1 == ORIENT_COLLINEAR) && b_within_q[0]) begin
      hit = 1'b1;
    end
    if ((o2 == ORIENT_COLLINEAR) && b_within_q[1]) begin
      hit = 1'b1;
    end
    if ((o3 == ORIENT_COLLINEAR) && b_within_q[2]) begin
      hit = 1'b1;
    end
    if ((o4 == ORIENT_COLLINEAR) && b_within_q[3]) begin
      hit = 1'b1;
    end
    hit = hit && b_live_q;

    // a beat without a segment opens a fresh path
    run_base = b_live_q && hit_so_far_q;

    out_beat_d.segment_hit  = hit;
    out_beat_d.path_crosses = run_base || hit;
    out_beat_d.path_done    = b_last_q;

    hit_so_far_d = hit_so_far_q;
    if (load_c) begin
      hit_so_far_d = b_last_q ? 1'b0 : (run_base || hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      hit_so_far_q <= 1'b0;
    end else begin
      hit_so_far_q <= hit_so_far_d;
      if (ready_c) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_c) begin
      out_beat_q <= out_beat_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

`ifndef ASSERT_OFF
  // a hit of this segment always shows in the running or
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (!out_beat_o.segment_hit || out_beat_o.path_crosses))
    else $error("segment hit without path crossing");

  // running or is cleared once the closing beat of a path is produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_c && b_last_q) |=> !hit_so_far_q)
    else $error("running or survived the end of a path");

  // no previous point is held after the last point of a path is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_beat_i.last_point) |=> !have_prev_q)
    else $error("previous point kept across a path end");

  // a segment without a previous point can never report a hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load_c && !b_live_q) |=> !out_beat_o.segment_hit)
    else $error("hit reported for a path start");
`endif

endmodule
